@@ src/arpbt_pkg.sv @@
// Package for the ARP binding table: status codes, slot state codes, sizes.
package arpbt_pkg;

  // Default number of binding slots
  localparam int ENTRY_COUNT_DEF = 16;

  // Result status codes
  localparam logic [2:0] RES_COMMITTED = 3'd0;
  localparam logic [2:0] RES_BAD_ARG   = 3'd1;
  localparam logic [2:0] RES_FULL      = 3'd2;
  localparam logic [2:0] RES_HIT       = 3'd3;
  localparam logic [2:0] RES_MISS      = 3'd4;
  localparam logic [2:0] RES_BLOCKED   = 3'd5;

  // Request function codes
  localparam logic FUNC_COMMIT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Slot state codes (code 3 is never written, behaves as valid)
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_VALID   = 2'd1;
  localparam logic [1:0] SLOT_EXPIRED = 2'd2;

  // Group (multicast) bit of the first MAC byte
  localparam int MAC_GROUP_BIT = 40;

  // Payload of one slot held in the table memory
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [63:0] deadline;
  } slot_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESULT = 4'b1000
  } seq_state_t;

endpackage

@@ src/arp_binding_table.sv @@
// ARP binding table: IPv4-to-MAC cache with lease expiry, scanned one slot per cycle.
//
//   channel | signals                                         | role
//   --------+-------------------------------------------------+---------------------------
//   in      | in_valid, in_ready, func, ip_addr, mac_in,      | commit / lookup request
//           | epoch_in, now_time, lease_len                   |
//   out     | out_valid, out_ready, status, mac_out           | one result per request
//
// Cycles: one slot read and compared per cycle. Commit: every slot is scanned, then a
// commit step writes the target and the result step follows. Lookup: ends at the first
// match, or after the last slot on a miss. Bad argument: no scan, straight to the result step.
// Reset: rst clears every slot to empty at once; no clearing pass is needed.
// Stalls: a result waiting in the output register does not block the next accept;
// that request's scan then holds in its result step until out_ready frees it.
module arp_binding_table #(
  parameter int ENTRY_COUNT = arpbt_pkg::ENTRY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_in,
  input  logic [31:0] epoch_in,
  input  logic [63:0] now_time,
  input  logic [31:0] lease_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [47:0] mac_out
);
  import arpbt_pkg::*;

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  // Sequencer
  seq_state_t state, state_next;

  // Latched request
  logic        req_func;
  logic [31:0] req_ip;
  logic [47:0] req_mac;
  logic [63:0] req_now;
  logic [63:0] req_deadline;

  // Slot state flops (reset clears) and slot payload memory
  logic [1:0] slot_state [ENTRY_COUNT];
  slot_t      slot_mem   [ENTRY_COUNT];

  // Scan pipeline: issue stage and compare stage
  logic [IDX_W-1:0] rd_idx;
  logic             issue_done;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic [1:0]       st_q;
  slot_t            mem_q;

  // Commit target tracking
  logic             pick_ok;
  logic [IDX_W-1:0] pick_idx;
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;

  // Result held until the output register frees
  logic [2:0]  res_status;
  logic [47:0] res_mac;

  // Request check and saturating deadline at accept
  logic        accept;
  logic        arg_bad;
  logic [64:0] dl_sum;

  // Compare-stage decode
  logic cmp_match;
  logic cmp_last;
  logic lk_finish;
  logic lk_expire;
  logic commit_wr;
  logic [IDX_W-1:0] commit_idx;
  logic out_load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign dl_sum   = {1'b0, now_time} + 65'(lease_len);

  always_comb begin
    if (func == FUNC_COMMIT) begin
      arg_bad = (ip_addr == 32'd0) || (epoch_in == 32'd0) || (lease_len == 32'd0) ||
                mac_in[MAC_GROUP_BIT] || (mac_in == 48'd0);
    end else begin
      arg_bad = (ip_addr == 32'd0);
    end
  end

  // The shared compare: one slot per cycle
  assign cmp_match = (st_q != SLOT_EMPTY) && (mem_q.ip == req_ip);
  assign cmp_last  = (cmp_idx == LAST_IDX);
  assign lk_finish = (state == S_SCAN) && cmp_vld && (req_func == FUNC_LOOKUP) &&
                     (cmp_match || cmp_last);
  // First match not yet expired but deadline reached: mark it expired
  assign lk_expire = (state == S_SCAN) && cmp_vld && (req_func == FUNC_LOOKUP) &&
                     cmp_match && (st_q != SLOT_EXPIRED) && (req_now >= mem_q.deadline);

  // Commit writes the last match, else the first empty slot
  assign commit_wr  = (state == S_COMMIT) && (pick_ok || free_ok);
  assign commit_idx = pick_ok ? pick_idx : free_idx;

  assign out_load = (state == S_RESULT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = arg_bad ? S_RESULT : S_SCAN;
      end
      S_SCAN: begin
        if (lk_finish) begin
          state_next = S_RESULT;
        end else if (cmp_vld && cmp_last && (req_func == FUNC_COMMIT)) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: state_next = S_RESULT;
      S_RESULT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      issue_done <= 1'b0;
      cmp_vld    <= 1'b0;
      rd_idx     <= '0;
      pick_ok    <= 1'b0;
      free_ok    <= 1'b0;
      for (int i = 0; i < ENTRY_COUNT; i++) slot_state[i] <= SLOT_EMPTY;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        rd_idx     <= '0;
        issue_done <= 1'b0;
        cmp_vld    <= 1'b0;
        pick_ok    <= 1'b0;
        free_ok    <= 1'b0;
      end else if (state == S_SCAN) begin
        cmp_vld <= !issue_done;
        if (!issue_done) begin
          rd_idx <= rd_idx + 1'b1;
          if (rd_idx == LAST_IDX) issue_done <= 1'b1;
        end
        if (cmp_vld && (req_func == FUNC_COMMIT)) begin
          if (cmp_match) pick_ok <= 1'b1;
          if ((st_q == SLOT_EMPTY) && !free_ok) free_ok <= 1'b1;
        end
      end

      if (lk_expire) begin
        slot_state[cmp_idx] <= SLOT_EXPIRED;
      end else if (commit_wr) begin
        slot_state[commit_idx] <= SLOT_VALID;
      end
    end
  end

  // Payload registers and table memory
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func     <= func;
      req_ip       <= ip_addr;
      req_mac      <= mac_in;
      req_now      <= now_time;
      req_deadline <= dl_sum[64] ? '1 : dl_sum[63:0];
      res_status   <= RES_BAD_ARG;
      res_mac      <= '0;
    end

    if ((state == S_SCAN) && !issue_done) begin
      mem_q   <= slot_mem[rd_idx];
      st_q    <= slot_state[rd_idx];
      cmp_idx <= rd_idx;
    end

    if ((state == S_SCAN) && cmp_vld && (req_func == FUNC_COMMIT)) begin
      if (cmp_match) pick_idx <= cmp_idx;
      if ((st_q == SLOT_EMPTY) && !free_ok) free_idx <= cmp_idx;
    end

    if (lk_finish) begin
      res_mac <= '0;
      if (!cmp_match) begin
        res_status <= RES_MISS;
      end else if ((st_q == SLOT_EXPIRED) || (req_now >= mem_q.deadline)) begin
        res_status <= RES_BLOCKED;
      end else begin
        res_status <= RES_HIT;
        res_mac    <= mem_q.mac;
      end
    end

    if (state == S_COMMIT) begin
      res_status <= commit_wr ? RES_COMMITTED : RES_FULL;
      res_mac    <= '0;
    end

    if (commit_wr) begin
      slot_mem[commit_idx] <= '{ip: req_ip, mac: req_mac, deadline: req_deadline};
    end

    if (out_load) begin
      status  <= res_status;
      mac_out <= res_mac;
    end
  end

endmodule
